// ===== rtl/ddma_pkg.sv =====
// ----------------------------------------------------------------------------
// Descriptor DMA engine package
// Shared types, codes and the decoded-descriptor type for the DMA engine.
// ----------------------------------------------------------------------------
`default_nettype none
package ddma_pkg;

	localparam int XMemLimitDefault = 16384;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_STEP  = 2'd2;

	localparam logic [1:0] REG_CONFIG  = 2'd0;
	localparam logic [1:0] REG_CONTROL = 2'd1;
	localparam logic [1:0] REG_START   = 2'd2;
	localparam logic [1:0] REG_NEXT    = 2'd3;

	localparam logic [2:0] ACT_START    = 3'd1;
	localparam logic [2:0] ACT_STOP     = 3'd2;
	localparam logic [2:0] ACT_FREEZE   = 3'd3;
	localparam logic [2:0] ACT_UNFREEZE = 3'd4;

	localparam logic [2:0] ERR_NONE   = 3'd0;
	localparam logic [2:0] ERR_DADDR  = 3'd1;
	localparam logic [2:0] ERR_FORMAT = 3'd2;
	localparam logic [2:0] ERR_BUFFER = 3'd3;
	localparam logic [2:0] ERR_REGION = 3'd4;
	localparam logic [2:0] ERR_OVFL   = 3'd5;
	localparam logic [2:0] ERR_ACTION = 3'd6;

	localparam logic [1:0] TGT_X   = 2'd0;
	localparam logic [1:0] TGT_Y   = 2'd1;
	localparam logic [1:0] TGT_P   = 2'd2;
	localparam logic [1:0] TGT_SCR = 2'd3;

	localparam logic [31:0] MASK24 = 32'h00FF_FFFF;

	typedef enum logic [2:0] {
		PH_IDLE, PH_LAUNCH, PH_DESC_ISSUE, PH_DESC, PH_XFER, PH_RD
	} phase_t;

	// One accepted item as it travels from the front part to the engine.
	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  reg_index;
		logic [31:0] write_value;
		logic [31:0] read_data;
	} item_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic        req_valid;
		logic [1:0]  req_target;
		logic        req_write;
		logic [31:0] req_address;
		logic [31:0] req_data;
		logic        busy_res;
		logic        end_of_list;
		logic [2:0]  error_code;
	} result_t;

	// Decoded descriptor, computed once after the last descriptor word lands.
	typedef struct packed {
		logic [2:0]  err;
		logic        to_scratch;
		logic [1:0]  target;
		logic [31:0] dsp_base;
		logic [32:0] scr_base;
		logic [31:0] count;
	} xfer_t;

endpackage
`default_nettype wire

// ===== rtl/ddma_front.sv =====
// ----------------------------------------------------------------------------
// Descriptor DMA front end
// Accepts input transfers and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
`default_nettype none
module ddma_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire ddma_pkg::item_t in_item,
	output logic                 q_valid,
	input  wire logic            q_ready,
	output ddma_pkg::item_t      q_item
);
	import ddma_pkg::*;

	item_t      mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !pop) else $error("queue underflow");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");
endmodule
`default_nettype wire

// ===== rtl/ddma_engine.sv =====
// ----------------------------------------------------------------------------
// Descriptor DMA engine back end
// Registers, descriptor walk and request generation, one item per cycle while the output is not held off.
// ----------------------------------------------------------------------------
`default_nettype none
module ddma_engine #(
	parameter int X_MEM_LIMIT = ddma_pkg::XMemLimitDefault
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	output logic                 q_ready,
	input  wire ddma_pkg::item_t q_item,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output ddma_pkg::result_t    out_res
);
	import ddma_pkg::*;

	logic [31:0] config_q, start_q, next_q, hold_q;
	logic        frozen_q, running_q, stopped_q, eol_q;
	logic [23:0] wcnt_q;
	logic [31:0] desc_q [7];
	phase_t      phase_q, phase_d;
	xfer_t       dec_q, dec_d;
	logic        dec_en;

	logic [31:0] next_d, hold_d;
	logic        frozen_d, running_d, stopped_d, eol_d;
	logic [23:0] wcnt_d;
	logic        desc_we;
	logic [2:0]  desc_idx;
	result_t     res;
	logic        fire;

	assign q_ready = !out_valid || out_ready;
	assign fire    = q_valid && q_ready;

	// Combinational decode of the descriptor words as they stand after this item.
	function automatic xfer_t decode(input logic [31:0] w1, input logic [31:0] w2,
			input logic [31:0] w3, input logic [31:0] w4, input logic [31:0] w5,
			input logic [31:0] w6);
		xfer_t       x;
		logic [2:0]  fmt;
		logic [3:0]  buf_id;
		logic [31:0] ssize;
		logic [33:0] lim;
		x      = '0;
		fmt    = w1[12:10];
		buf_id = w1[8:5];
		ssize  = w6 + 32'd1;
		lim    = '0;
		x.count      = w2;
		x.to_scratch = w1[1];
		if (fmt != 3'd2 && fmt != 3'd6) begin
			x.err = ERR_FORMAT;
		end else if (buf_id == 4'he && ({2'b0, w4} + {w2, 2'b0}) >= {2'b0, ssize}) begin
			x.err = ERR_BUFFER;
		end else if (buf_id != 4'he && buf_id != 4'hf) begin
			x.err = ERR_BUFFER;
		end else begin
			x.scr_base = (buf_id == 4'he) ? ({1'b0, w5} + {1'b0, w4}) : {1'b0, w4};
			if (w3 < 32'h1800) begin
				x.target = TGT_X; lim = 34'h1800; x.dsp_base = w3;
			end else if (w3 < 32'h2000) begin
				x.target = TGT_Y; lim = 34'h2000; x.dsp_base = w3 - 32'h1800;
			end else if (w3 >= 32'h2800 && w3 < 32'h3800) begin
				x.target = TGT_P; lim = 34'h3800; x.dsp_base = w3 - 32'h2800;
			end else begin
				x.err = ERR_REGION;
			end
			if (x.err == ERR_NONE) begin
				if (({2'b0, w3} + {2'b0, w2}) >= lim) x.err = ERR_REGION;
				else if (({2'b0, x.scr_base} + {w2, 2'b0}) > 35'h1_0000_0000)
					x.err = ERR_OVFL;
			end
		end
		return x;
	endfunction

	always_comb begin
		logic [2:0]  err;
		logic [31:0] addr;
		logic        do_xfer, do_launch;
		logic [2:0]  act;
		err       = ERR_NONE;
		res       = '0;
		phase_d   = phase_q;
		next_d    = next_q;
		hold_d    = hold_q;
		frozen_d  = frozen_q;
		running_d = running_q;
		stopped_d = stopped_q;
		eol_d     = eol_q;
		wcnt_d    = wcnt_q;
		desc_we   = 1'b0;
		desc_idx  = wcnt_q[2:0];
		dec_en    = 1'b0;
		dec_d     = decode(desc_q[1], desc_q[2], desc_q[3], desc_q[4], desc_q[5],
			desc_q[6]);
		do_xfer   = 1'b0;
		do_launch = 1'b0;
		act       = q_item.write_value[2:0];
		addr      = {18'd0, next_q[13:0]};
		unique case (q_item.kind)
			KIND_READ: begin
				unique case (q_item.reg_index)
					REG_CONFIG:  res.read_value = config_q;
					REG_CONTROL: res.read_value = {26'd0, stopped_q, running_q, frozen_q,
						3'd0};
					REG_START:   res.read_value = start_q;
					default:     res.read_value = next_q;
				endcase
			end
			KIND_WRITE: begin
				if (q_item.reg_index == REG_NEXT) next_d = q_item.write_value;
				if (q_item.reg_index == REG_CONTROL) begin
					unique case (act)
						ACT_START:    begin running_d = 1'b1; stopped_d = 1'b0; end
						ACT_STOP:     begin running_d = 1'b0; stopped_d = 1'b1; end
						ACT_FREEZE:   frozen_d = 1'b1;
						ACT_UNFREEZE: frozen_d = 1'b0;
						default:      err = ERR_ACTION;
					endcase
					if (err == ERR_NONE) begin
						if (!running_d) phase_d = PH_IDLE;
						else if (!frozen_d && phase_q == PH_IDLE) phase_d = PH_LAUNCH;
					end
				end
			end
			KIND_STEP: begin
				if (phase_q == PH_IDLE) begin
					phase_d = PH_IDLE;
				end else if (!running_q) begin
					phase_d = PH_IDLE;
				end else if (frozen_q) begin
					if (phase_q == PH_DESC) phase_d = PH_DESC_ISSUE;
					else if (phase_q == PH_RD) phase_d = PH_XFER;
				end else begin
					unique case (phase_q)
						PH_LAUNCH: do_launch = 1'b1;
						PH_DESC_ISSUE: begin
							res.req_valid   = 1'b1;
							res.req_target  = TGT_X;
							res.req_address = hold_q + {29'd0, wcnt_q[2:0]};
							phase_d = PH_DESC;
						end
						PH_DESC: begin
							desc_we = (wcnt_q < 24'd7);
							if (wcnt_q < 24'd6) begin
								wcnt_d = wcnt_q + 24'd1;
								res.req_valid   = 1'b1;
								res.req_target  = TGT_X;
								res.req_address = hold_q + {8'd0, wcnt_q} + 32'd1;
							end else begin
								// Last word arrives now; decode with it in place.
								dec_d = decode(desc_q[1], desc_q[2], desc_q[3], desc_q[4],
									desc_q[5], q_item.read_data);
								dec_en = 1'b1;
								if (dec_d.err != ERR_NONE) err = dec_d.err;
								else begin
									wcnt_d  = '0;
									phase_d = PH_XFER;
									do_xfer = 1'b1;
								end
							end
						end
						PH_XFER: begin
							dec_d = dec_q;
							if (dec_q.err != ERR_NONE) err = dec_q.err;
							else do_xfer = 1'b1;
						end
						PH_RD: begin
							dec_d = dec_q;
							if (dec_q.err != ERR_NONE) err = dec_q.err;
							else begin
								hold_d = q_item.read_data;
								res.req_valid = 1'b1;
								res.req_write = 1'b1;
								if (dec_q.to_scratch) begin
									res.req_target  = TGT_SCR;
									res.req_address = dec_q.scr_base[31:0] + {6'd0, wcnt_q, 2'b0};
									res.req_data    = q_item.read_data;
								end else begin
									res.req_target  = dec_q.target;
									res.req_address = dec_q.dsp_base + {8'd0, wcnt_q};
									res.req_data    = q_item.read_data & MASK24;
								end
								wcnt_d  = wcnt_q + 24'd1;
								phase_d = PH_XFER;
							end
						end
						default: phase_d = PH_IDLE;
					endcase
					if (do_xfer) begin
						// Counter compare is against the full 32-bit count.
						if ({8'd0, (phase_q == PH_DESC) ? 24'd0 : wcnt_q} >= dec_d.count) begin
							next_d = desc_q[0];
							if (desc_q[0][14]) begin
								eol_d = 1'b1; phase_d = PH_IDLE;
							end else begin
								do_launch = 1'b1;
								addr = {18'd0, desc_q[0][13:0]};
							end
						end else begin
							res.req_valid = 1'b1;
							if (dec_d.to_scratch) begin
								res.req_target  = dec_d.target;
								res.req_address = dec_d.dsp_base +
									{8'd0, (phase_q == PH_DESC) ? 24'd0 : wcnt_q};
							end else begin
								res.req_target  = TGT_SCR;
								res.req_address = dec_d.scr_base[31:0] +
									{6'd0, (phase_q == PH_DESC) ? 24'd0 : wcnt_q, 2'b0};
							end
							phase_d = PH_RD;
						end
					end
					if (do_launch) begin
						if (!do_xfer && next_q[14]) begin
							phase_d = PH_IDLE;
						end else if (addr + 32'd6 >= 32'(X_MEM_LIMIT)) begin
							err = ERR_DADDR;
						end else begin
							hold_d  = addr;
							wcnt_d  = '0;
							res.req_valid   = 1'b1;
							res.req_target  = TGT_X;
							res.req_address = addr;
							phase_d = PH_DESC;
						end
					end
				end
			end
			default: ;
		endcase
		if (err != ERR_NONE) begin
			running_d = 1'b0;
			stopped_d = 1'b1;
			phase_d   = PH_IDLE;
			res.req_valid = 1'b0; res.req_target = '0; res.req_write = 1'b0;
			res.req_address = '0; res.req_data = '0;
		end
		res.busy_res    = (phase_d != PH_IDLE);
		res.end_of_list = eol_d;
		res.error_code  = err;
	end

	always_ff @(posedge clk) begin
		if (fire && desc_we) desc_q[desc_idx] <= q_item.read_data;
		if (fire && dec_en) dec_q <= dec_d;
		if (fire) out_res <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			config_q <= '0; start_q <= '0; next_q <= '0; hold_q <= '0;
			frozen_q <= 1'b0; running_q <= 1'b0; stopped_q <= 1'b0; eol_q <= 1'b0;
			wcnt_q <= '0; phase_q <= PH_IDLE; out_valid <= 1'b0;
		end else begin
			if (fire) begin
				if (q_item.kind == KIND_WRITE && q_item.reg_index == REG_CONFIG)
					config_q <= q_item.write_value;
				if (q_item.kind == KIND_WRITE && q_item.reg_index == REG_START)
					start_q <= q_item.write_value;
				next_q <= next_d; hold_q <= hold_d;
				frozen_q <= frozen_d; running_q <= running_d; stopped_q <= stopped_d;
				eol_q <= eol_d; wcnt_q <= wcnt_d; phase_q <= phase_d;
			end
			if (fire) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	function automatic logic err_seen();
		return res.error_code != ERR_NONE;
	endfunction

	a_eol_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		eol_q |=> eol_q) else $error("eol flag cleared");
	a_err_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && err_seen()) |=> phase_q == PH_IDLE && stopped_q)
		else $error("error did not stop engine");
	a_run_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(running_q && stopped_q)) else $error("running and stopped");
endmodule
`default_nettype wire

// ===== rtl/dsp_descriptor_dma_engine_core.sv =====
// Path: each input transfer is registered in the input queue and then in the
// engine's output register; results wait longer while the output is held off.
// Throughput: one item per cycle while the output is not held off; the engine's
// combinational decode and request path allows this, and a two-entry queue decouples input.
// Reset (arst_n low, asynchronous) clears control registers, flags, word count and phase to idle.
// ----------------------------------------------------------------------------
// Descriptor DMA engine core
// Front queue plus descriptor-walking engine behind a stream interface.
// ----------------------------------------------------------------------------
`default_nettype none
module dsp_descriptor_dma_engine_core #(
	parameter int X_MEM_LIMIT = ddma_pkg::XMemLimitDefault
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// kind[1:0], reg_index[3:2], write_value[35:4], read_data[67:36], zero fill
	input  wire logic [71:0]  s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// read_value[31:0], req_valid[32], req_target[34:33], req_write[35],
	// req_address[67:36], req_data[99:68], busy_res[100], end_of_list[101],
	// error_code[104:102], zero fill
	output logic [111:0]      m_axis_tdata
);
	import ddma_pkg::*;

	item_t   in_item, q_item;
	result_t res;
	logic    q_valid, q_ready;

	assign in_item.kind        = s_axis_tdata[1:0];
	assign in_item.reg_index   = s_axis_tdata[3:2];
	assign in_item.write_value = s_axis_tdata[35:4];
	assign in_item.read_data   = s_axis_tdata[67:36];

	ddma_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item,
		.q_valid, .q_ready, .q_item
	);

	ddma_engine #(.X_MEM_LIMIT(X_MEM_LIMIT)) u_engine (
		.clk, .arst_n, .q_valid, .q_ready, .q_item,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
	);

	assign m_axis_tdata = {7'd0, res.error_code, res.end_of_list, res.busy_res,
		res.req_data, res.req_address, res.req_write, res.req_target, res.req_valid,
		res.read_value};
endmodule
`default_nettype wire
